### rtl/mmp_pkg.sv
// mmp_pkg: types and constants shared by the midi message parser
// used by mmp_core and midi_message_parser, depends on nothing else
package mmp_pkg;

    // number of data bytes in a note off, note on or pitch bend message
    localparam int unsigned DATA_BYTES = 2;

    // status byte constants
    localparam logic [7:0] STATUS_FLAG  = 8'h80;
    localparam logic [7:0] SYS_BASE     = 8'hF0;
    localparam logic [7:0] CHANNEL_MASK = 8'h0F;

    // command codes (upper nibble for channel messages, whole byte otherwise)
    localparam logic [7:0] CMD_NOTE_OFF   = 8'h80;
    localparam logic [7:0] CMD_NOTE_ON    = 8'h90;
    localparam logic [7:0] CMD_PITCH_BEND = 8'hE0;
    localparam logic [7:0] CMD_SYS_RESET  = 8'hFF;

    // message kind codes on the result channel
    localparam logic [1:0] KIND_NOTE_OFF   = 2'd0;
    localparam logic [1:0] KIND_NOTE_ON    = 2'd1;
    localparam logic [1:0] KIND_PITCH_BEND = 2'd2;
    localparam logic [1:0] KIND_SYS_RESET  = 2'd3;

    // what the stored status expects next
    typedef enum logic [1:0] {
        MSG_FILTERED = 2'd0,
        MSG_TWO_DATA = 2'd1,
        MSG_NO_DATA  = 2'd2
    } msg_class_t;

    // one completed message
    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] midi_channel;
        logic [6:0] first_data;
        logic [6:0] second_data;
    } mmp_result_t;

endpackage

### rtl/mmp_core.sv
// mmp_core: running status state and per-byte message decode
// depends on mmp_pkg
module mmp_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           midi_byte,
    output logic                 emit,
    output mmp_pkg::mmp_result_t result
);

    logic [7:0]          status_reg,  status_next;
    logic [6:0]          data0_reg,   data0_next;
    logic [6:0]          data1_reg,   data1_next;
    logic                head_reg,    head_next;
    mmp_pkg::msg_class_t class_reg,   class_next;

    logic [7:0]          cmd;
    logic [1:0]          count;
    logic [1:0]          kind;

    // command of the incoming byte, if it is a status byte
    always_comb
    begin
        if (midi_byte >= mmp_pkg::SYS_BASE)
            cmd = midi_byte;
        else
            cmd = midi_byte & ~mmp_pkg::CHANNEL_MASK;
    end

    // state update for one byte
    always_comb
    begin
        status_next = status_reg;
        data0_next  = data0_reg;
        data1_next  = data1_reg;
        class_next  = class_reg;
        count       = {1'b0, head_reg};
        if ((midi_byte & mmp_pkg::STATUS_FLAG) != 8'h00)
        begin
            status_next = midi_byte;
            count       = 2'd0;
            if (cmd == mmp_pkg::CMD_NOTE_OFF || cmd == mmp_pkg::CMD_NOTE_ON ||
                cmd == mmp_pkg::CMD_PITCH_BEND)
                class_next = mmp_pkg::MSG_TWO_DATA;
            else if (cmd == mmp_pkg::CMD_SYS_RESET)
                class_next = mmp_pkg::MSG_NO_DATA;
            else
                class_next = mmp_pkg::MSG_FILTERED;
        end
        else if (class_reg == mmp_pkg::MSG_TWO_DATA)
        begin
            if (head_reg)
                data1_next = midi_byte[6:0];
            else
                data0_next = midi_byte[6:0];
            count = {1'b0, head_reg} + 2'd1;
        end
    end

    // message completion
    always_comb
    begin
        case (class_next)
            mmp_pkg::MSG_NO_DATA:  emit = 1'b1;
            mmp_pkg::MSG_TWO_DATA: emit = (count == 2'(mmp_pkg::DATA_BYTES));
            default:               emit = 1'b0;
        endcase
        head_next = emit ? 1'b0 : count[0];
    end

    // kind from the upper nibble of the stored status
    always_comb
    begin
        case (status_next & ~mmp_pkg::CHANNEL_MASK)
            mmp_pkg::CMD_NOTE_OFF:   kind = mmp_pkg::KIND_NOTE_OFF;
            mmp_pkg::CMD_NOTE_ON:    kind = mmp_pkg::KIND_NOTE_ON;
            mmp_pkg::CMD_PITCH_BEND: kind = mmp_pkg::KIND_PITCH_BEND;
            default:                 kind = mmp_pkg::KIND_SYS_RESET;
        endcase
        result.kind         = kind;
        result.midi_channel = status_next[3:0];
        result.first_data   = data0_next;
        result.second_data  = data1_next;
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= 8'h00;
            data0_reg  <= 7'h00;
            data1_reg  <= 7'h00;
            head_reg   <= 1'b0;
            class_reg  <= mmp_pkg::MSG_FILTERED;
        end
        else if (step)
        begin
            status_reg <= status_next;
            data0_reg  <= data0_next;
            data1_reg  <= data1_next;
            head_reg   <= head_next;
            class_reg  <= class_next;
        end
    end

endmodule

### rtl/midi_message_parser.sv
// midi_message_parser: top level, input register, decode core and result register
// depends on mmp_pkg and mmp_core
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | in_valid / in_stall    | midi_byte
//  result   | out_valid / out_stall  | kind, midi_channel, first_data, second_data
//
// one byte a cycle when not stalled: an accepted byte sits in the input register
// and is decoded from there; its message, if any, is registered into the result
// register once that register is free
// throughput is one byte per cycle while the result is not stalled, set by the single input register
// reset clears the running status, stored data and both valid flags
// a stalled result holds the input register; with no stall nothing waits
module midi_message_parser
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] midi_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [3:0] midi_channel,
    output logic [6:0] first_data,
    output logic [6:0] second_data
);

    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           byte_reg;
    logic                 out_valid_reg, out_valid_next;
    mmp_pkg::mmp_result_t result_reg;

    logic                 slot_free;
    logic                 go;
    logic                 emit;
    mmp_pkg::mmp_result_t result;

    // stage control
    assign slot_free = !out_valid_reg || !out_stall;
    assign go        = in_valid_reg && slot_free;
    assign in_stall  = in_valid_reg && !slot_free;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (!in_stall)
            in_valid_next = in_valid;
        out_valid_next = out_valid_reg;
        if (slot_free)
            out_valid_next = go && emit;
    end

    // decode core
    mmp_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (go),
        .midi_byte (byte_reg),
        .emit      (emit),
        .result    (result)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            byte_reg <= midi_byte;
        if (go && emit)
            result_reg <= result;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = result_reg.kind;
    assign midi_channel = result_reg.midi_channel;
    assign first_data   = result_reg.first_data;
    assign second_data  = result_reg.second_data;

endmodule
